[rtl/core/lsme_pkg.sv]
// ----------------------------------------------------------------------------
// lsme_pkg
// Shared types and constants for the hidden message extractor: report kinds,
// register indexes, result word layout and result queue sizing.
// ----------------------------------------------------------------------------
package lsme_pkg;

	// register file
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;
	localparam logic [7:0] START_CODE_RST = 8'h02;
	localparam logic [7:0] END_CODE_RST   = 8'h03;

	// byte assembly
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);

	// report kinds
	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_NOSTART = 2'd2,
		KIND_NOEND   = 2'd3
	} kind_t;

	// extraction phase, one-hot
	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_MSG   = 3'b010,
		PH_DONE  = 3'b100
	} phase_t;

	// one result word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic       last_of_run;
	} res_t;

	// results of one pixel, handed to the result queue
	typedef struct packed {
		logic       en;
		logic [1:0] num;
		res_t       first;
		res_t       second;
	} push_t;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              room;
		logic [QCNT_W-1:0] level;
	} qstat_t;

endpackage

[rtl/core/lsb_stego_message_extract_top.sv]
// ----------------------------------------------------------------------------
// lsb_stego_message_extract_top
// Pulls a hidden byte message out of the pixel LSBs of a grey image stream
// and reports characters, completion and the two failure cases.
//
// channel  dir  tdata / data       tuser        tlast
// s_axis   in   pixel_value[7:0]   -            last_pixel
// m_axis   out  char_value[7:0]    report_kind  last_of_run
// cfg      in   cfg_data[7:0]      -            -   (cfg_index selects reg)
//
// one pixel per cycle while the result queue has room; a result is offered
// on m_axis once its pixel has passed the input register and the result queue
// the two results of a pixel leave one at a time through the
// one-word-per-cycle read port of the four-entry result queue
// m_axis stalls back up into the queue and then the input register
// config writes are always accepted (cfg_ready is always high)
// reset clears extraction state and restores start code 2, end code 3
// ----------------------------------------------------------------------------
module lsb_stego_message_extract_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel_value
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] char_value
	output logic [1:0]                     m_axis_tuser,  // [1:0] report_kind
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lsme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	lsme_pkg::push_t  push;
	lsme_pkg::qstat_t qstat;
	lsme_pkg::res_t   out_res;
	logic             busy;

	assign cfg_ready = 1'b1;

	// byte assembly
	lsme_extract u_extract (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.pixel_value (s_axis_tdata),
		.last_pixel  (s_axis_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.qstat       (qstat),
		.push        (push),
		.busy        (busy)
	);

	// result queue
	lsme_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.qstat     (qstat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.char_value;
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_of_run;

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= lsme_pkg::QCNT_W'(lsme_pkg::QDEPTH))
		else $error("result queue overflow");

	// only character words carry a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != lsme_pkg::KIND_CHAR)) |-> (m_axis_tdata == 8'h00))
		else $error("non-character word with nonzero byte");

	// words from a pixel are only pushed when the queue had room
	assert property (@(posedge clk) disable iff (!arst_n)
		push.en |-> qstat.room)
		else $error("push without room");

	// input side only stalls while a pixel waits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (busy && !qstat.room))
		else $error("input stalled without cause");

endmodule

[rtl/core/lsme_extract.sv]
// ----------------------------------------------------------------------------
// lsme_extract
// Input register, register file and per-pixel byte assembly. Each pixel
// leaves the input register with zero, one or two result words.
// ----------------------------------------------------------------------------
module lsme_extract (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    pixel_value,
	input  logic                          last_pixel,
	input  logic                          cfg_valid,
	input  logic [lsme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  lsme_pkg::qstat_t              qstat,
	output lsme_pkg::push_t               push,
	output logic                          busy
);

	logic                            valid_s1;
	logic                            bit_s1;
	logic                            last_s1;
	logic                            advance;
	logic [7:0]                      start_code_q;
	logic [7:0]                      end_code_q;
	logic [lsme_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic [7:0]                      acc_q;
	lsme_pkg::phase_t                phase_q;

	logic                            active;
	logic [7:0]                      acc_next;
	logic                            byte_done;
	logic                            byte_emit;
	lsme_pkg::res_t                  byte_res;
	lsme_pkg::phase_t                phase_after;
	logic                            tail_emit;
	lsme_pkg::res_t                  tail_res;

	// pixel leaves the input register when the queue has room for two words
	assign advance  = valid_s1 && qstat.room;
	assign in_ready = !valid_s1 || qstat.room;
	assign busy     = valid_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bit_s1  <= pixel_value[0];
			last_s1 <= last_pixel;
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= lsme_pkg::START_CODE_RST;
			end_code_q   <= lsme_pkg::END_CODE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lsme_pkg::CFG_START_CODE: start_code_q <= cfg_data;
				lsme_pkg::CFG_END_CODE:   end_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte assembly and checks
	always_comb begin
		active      = (phase_q == lsme_pkg::PH_START) || (phase_q == lsme_pkg::PH_MSG);
		acc_next    = {acc_q[6:0], bit_s1};
		byte_done   = active &&
			(bit_cnt_q == lsme_pkg::BIT_CNT_W'(lsme_pkg::BITS_PER_BYTE - 1));
		byte_emit   = 1'b0;
		byte_res    = '{kind: lsme_pkg::KIND_CHAR, char_value: 8'h00, last_of_run: 1'b0};
		phase_after = phase_q;
		if (byte_done) begin
			if (phase_q == lsme_pkg::PH_START) begin
				if (acc_next != start_code_q) begin
					byte_emit     = 1'b1;
					byte_res.kind = lsme_pkg::KIND_NOSTART;
					phase_after   = lsme_pkg::PH_DONE;
				end else begin
					phase_after = lsme_pkg::PH_MSG;
				end
			end else if (acc_next == end_code_q) begin
				byte_emit     = 1'b1;
				byte_res.kind = lsme_pkg::KIND_DONE;
				phase_after   = lsme_pkg::PH_DONE;
			end else begin
				byte_emit           = 1'b1;
				byte_res.char_value = acc_next;
			end
		end
		tail_emit = last_s1 && ((phase_after == lsme_pkg::PH_START) ||
			(phase_after == lsme_pkg::PH_MSG));
		tail_res  = '{kind: lsme_pkg::KIND_NOEND, char_value: 8'h00, last_of_run: 1'b1};
	end

	// order the words of this pixel and mark the final one
	always_comb begin
		push.en     = advance;
		push.first  = byte_res;
		push.second = tail_res;
		if (byte_emit) begin
			push.first.last_of_run = !tail_emit;
			push.num               = tail_emit ? 2'd2 : 2'd1;
		end else begin
			push.first = tail_res;
			push.num   = tail_emit ? 2'd1 : 2'd0;
		end
	end

	// extraction state, rearmed by the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			acc_q     <= '0;
			phase_q   <= lsme_pkg::PH_START;
		end else if (advance) begin
			if (last_s1) begin
				bit_cnt_q <= '0;
				acc_q     <= '0;
				phase_q   <= lsme_pkg::PH_START;
			end else begin
				phase_q <= phase_after;
				if (active) begin
					bit_cnt_q <= bit_cnt_q + lsme_pkg::BIT_CNT_W'(1);
					acc_q     <= byte_done ? 8'h00 : acc_next;
				end
			end
		end
	end

endmodule

[rtl/core/lsme_res_fifo.sv]
// ----------------------------------------------------------------------------
// lsme_res_fifo
// Small result queue: takes up to two words per cycle from the extractor,
// hands one word per cycle to the output side while it is ready.
// ----------------------------------------------------------------------------
module lsme_res_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  lsme_pkg::push_t  push,
	output lsme_pkg::qstat_t qstat,
	output logic             out_valid,
	input  logic             out_ready,
	output lsme_pkg::res_t   out_res
);

	lsme_pkg::res_t                 mem_q [lsme_pkg::QDEPTH];
	logic [lsme_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [lsme_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [lsme_pkg::QCNT_W-1:0]   count_q;
	logic                          pop;
	logic [lsme_pkg::QPTR_W-1:0]   wr_ptr_nxt1;
	logic [lsme_pkg::QCNT_W-1:0]   push_num;

	assign out_valid   = (count_q != '0);
	assign pop         = out_valid && out_ready;
	assign out_res     = mem_q[rd_ptr_q];
	assign wr_ptr_nxt1 = wr_ptr_q + lsme_pkg::QPTR_W'(1);
	assign push_num    = push.en ? lsme_pkg::QCNT_W'(push.num) : '0;

	// room for a full pixel's worth of words, not counting this cycle's pop
	assign qstat.room  = (count_q <= lsme_pkg::QCNT_W'(lsme_pkg::QDEPTH - 2));
	assign qstat.level = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push.en && (push.num != 2'd0)) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.en && (push.num == 2'd2)) begin
			mem_q[wr_ptr_nxt1] <= push.second;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lsme_pkg::QPTR_W'(push_num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lsme_pkg::QPTR_W'(1);
			end
			count_q <= count_q + push_num - lsme_pkg::QCNT_W'(pop);
		end
	end

endmodule

[sim/lsb_stego_message_extract_top_test.sv]
// ----------------------------------------------------------------------------
// lsb_stego_message_extract_top_test
// Streams grey images into the hidden message extractor and checks every
// report word against an in-bench model of the bit collector. The first
// images are fixed and cover the pixel extremes and the end-of-image cases.
// Random images follow, mostly well-formed messages with random content,
// under several start and end codes. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module lsb_stego_message_extract_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} pixel_t;

	// dut ports, inputs known from time zero
	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata  = 8'h00;  // [7:0] pixel_value
	logic                           s_axis_tlast  = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [7:0]                     m_axis_tdata;           // [7:0] char_value
	logic [1:0]                     m_axis_tuser;           // [1:0] report_kind
	logic                           m_axis_tlast;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [lsme_pkg::CFG_IDX_W-1:0] cfg_index     = lsme_pkg::CFG_START_CODE;
	logic [7:0]                     cfg_data      = 8'h00;

	// model of the extractor
	logic [2:0]        bit_cnt_m   = 3'd0;
	logic [7:0]        acc_m       = 8'h00;
	lsme_pkg::phase_t  ph_m        = lsme_pkg::PH_START;
	logic [7:0]        start_m     = lsme_pkg::START_CODE_RST;
	logic [7:0]        end_m       = lsme_pkg::END_CODE_RST;
	lsme_pkg::res_t    expected_reports[$];

	pixel_t      pixel_queue[$];
	int          error_count = 0;
	int          gap_left    = 0;
	int          burst_left  = 1;
	int          sink_mode   = 0;
	int          sink_left   = 0;
	logic [2:0]  sink_tick   = 3'd0;

	lsb_stego_message_extract_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// shift one pixel lsb into the model and queue the reports it causes
	task automatic extract_pixel(input logic [7:0] value, input logic last);
		logic [7:0]     b;
		lsme_pkg::res_t found[2];
		int             n;
		n = 0;
		if (ph_m != lsme_pkg::PH_DONE) begin
			b = {acc_m[6:0], value[0]};
			acc_m = b;
			bit_cnt_m = bit_cnt_m + 3'd1;
			if (bit_cnt_m == 3'd0) begin
				acc_m = 8'h00;
				if (ph_m == lsme_pkg::PH_START) begin
					if (b != start_m) begin
						found[n] = '{kind: lsme_pkg::KIND_NOSTART, char_value: 8'h00,
							last_of_run: 1'b0};
						n++;
						ph_m = lsme_pkg::PH_DONE;
					end else begin
						ph_m = lsme_pkg::PH_MSG;
					end
				end else if (b == end_m) begin
					found[n] = '{kind: lsme_pkg::KIND_DONE, char_value: 8'h00,
						last_of_run: 1'b0};
					n++;
					ph_m = lsme_pkg::PH_DONE;
				end else begin
					found[n] = '{kind: lsme_pkg::KIND_CHAR, char_value: b, last_of_run: 1'b0};
					n++;
				end
			end
		end
		// end of image always rearms
		if (last) begin
			if (ph_m != lsme_pkg::PH_DONE) begin
				found[n] = '{kind: lsme_pkg::KIND_NOEND, char_value: 8'h00,
					last_of_run: 1'b0};
				n++;
			end
			bit_cnt_m = 3'd0;
			acc_m = 8'h00;
			ph_m = lsme_pkg::PH_START;
		end
		if (n > 0)
			found[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			expected_reports.insert(expected_reports.size(), found[i]);
	endtask

	// pixel source: bursts of random length with random gaps
	always @(posedge clk) begin : source
		pixel_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				extract_pixel(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					nxt = pixel_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.value;
					s_axis_tlast  <= nxt.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// report sink: compare each word, then pick the next ready
	always @(posedge clk) begin : sink
		lsme_pkg::res_t want;
		logic           rdy;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					flag_error($sformatf("unexpected word kind %0d char %02h last %0d",
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
				end else begin
					want = expected_reports.pop_front();
					if (m_axis_tuser != want.kind)
						flag_error($sformatf("report_kind %0d, expected %0d",
							m_axis_tuser, want.kind));
					if (m_axis_tdata != want.char_value)
						flag_error($sformatf("char_value %02h, expected %02h",
							m_axis_tdata, want.char_value));
					if (m_axis_tlast != want.last_of_run)
						flag_error($sformatf("last_of_run %0d, expected %0d",
							m_axis_tlast, want.last_of_run));
				end
			end
			// stall pattern changes mode every so often
			if (sink_left == 0) begin
				sink_mode = $urandom_range(0, 3);
				sink_left = $urandom_range(20, 200);
			end else begin
				sink_left--;
			end
			sink_tick = sink_tick + 3'd1;
			case (sink_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = (sink_tick >= 3'd3);
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
			m_axis_tready <= rdy;
		end
	end

	task automatic queue_pixel(input logic [7:0] value, input logic last);
		pixel_queue.insert(pixel_queue.size(), '{value: value, last: last});
	endtask

	// image of whole bytes, msb first, then loose bits; random upper pixel bits
	task automatic queue_image(input logic [7:0] msg[$], input int tail);
		int         total;
		int         idx;
		logic [7:0] v;
		total = msg.size() * 8 + tail;
		if (total == 0) begin
			tail  = 1;
			total = 1;
		end
		idx = 0;
		foreach (msg[i]) begin
			for (int k = 7; k >= 0; k--) begin
				v = 8'($urandom);
				v[0] = msg[i][k];
				queue_pixel(v, idx == total - 1);
				idx++;
			end
		end
		for (int k = 0; k < tail; k++) begin
			v = 8'($urandom);
			queue_pixel(v, idx == total - 1);
			idx++;
		end
	endtask

	task automatic write_reg(input logic [lsme_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == lsme_pkg::CFG_START_CODE)
			start_m = val;
		else if (idx == lsme_pkg::CFG_END_CODE)
			end_m = val;
	endtask

	// all pixels taken, all reports seen, then let the pipeline drain
	task automatic wait_idle();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// random image mix: mostly well-formed messages
	task automatic queue_random_image(output int pixels);
		logic [7:0] msg[$];
		logic [7:0] b;
		int         r;
		int         tail;
		r = $urandom_range(0, 99);
		tail = 0;
		if (r < 75) begin
			msg.insert(msg.size(), start_m);
			repeat ($urandom_range(0, 6)) begin
				b = 8'($urandom);
				msg.insert(msg.size(), b);
			end
			if (r < 60) begin
				msg.insert(msg.size(), end_m);
				tail = $urandom_range(0, 12);
			end else begin
				tail = $urandom_range(0, 7);
			end
		end else if (r < 85) begin
			b = 8'($urandom);
			if (b == start_m)
				b = b ^ 8'h01;
			msg.insert(msg.size(), b);
			tail = $urandom_range(0, 12);
		end else begin
			tail = $urandom_range(1, 40);
		end
		queue_image(msg, tail);
		pixels = (msg.size() * 8 + tail == 0) ? 1 : msg.size() * 8 + tail;
	endtask

	// stimulus
	initial begin : stimulus
		logic [7:0] start_list[7];
		logic [7:0] end_list[7];
		int         phase_pixels;
		int         n;
		start_list = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, lsme_pkg::START_CODE_RST};
		end_list   = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, lsme_pkg::END_CODE_RST};
		start_list[4] = 8'($urandom);
		end_list[4]   = 8'($urandom);
		start_list[5] = 8'($urandom);
		end_list[5]   = start_list[5];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// one-pixel image ends before its first byte
		queue_pixel(8'hFF, 1'b1);
		// bad start byte on the last pixel gives only the no-start report
		for (int k = 0; k < 8; k++)
			queue_pixel(8'hFF, k == 7);
		// start byte, then a character that completes on the last pixel
		for (int k = 7; k >= 0; k--)
			queue_pixel(lsme_pkg::START_CODE_RST[k] ? 8'h01 : 8'h00, 1'b0);
		for (int k = 7; k >= 0; k--)
			queue_pixel(8'h41 >> k & 8'h01 ? 8'h01 : 8'hFE, k == 0);
		wait_idle();

		// random images under each code setting
		for (int p = 0; p < 7; p++) begin
			write_reg(lsme_pkg::CFG_START_CODE, start_list[p]);
			write_reg(lsme_pkg::CFG_END_CODE, end_list[p]);
			phase_pixels = 0;
			while (phase_pixels < 220) begin
				queue_random_image(n);
				phase_pixels += n;
			end
			wait_idle();
		end

		if (expected_reports.size() != 0)
			flag_error($sformatf("%0d reports never arrived", expected_reports.size()));
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hard stop
	initial begin : watchdog
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
